FILE: hw/rtl/psg_pkg.sv
// Shared types, constants and lookup functions for the tone and noise generator.
`timescale 1ns / 1ps

package psg_pkg;

    localparam int CLK_W      = 22;                 // clock numerator width
    localparam int DIV_W      = 16;                 // period times scale, widest case
    localparam int CNT_W      = $clog2(CLK_W + 1);  // divide step counter
    localparam int PER_LO_W   = 4;
    localparam int PER_HI_W   = 6;
    localparam int PER_W      = PER_LO_W + PER_HI_W;
    localparam int NPER_W     = 5;
    localparam int VOL_W      = 4;
    localparam int SEED_W     = 16;
    localparam int SAMPLE_W   = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [SEED_W-1:0] LCG_MULT = 16'd75;

    localparam logic [CLK_W-1:0] TONE_CLOCK_RESET  = 22'd111860;
    localparam logic [CLK_W-1:0] NOISE_CLOCK_RESET = 22'd6991;

    localparam logic [1:0] CFG_CHIP_ENABLE = 2'd0;
    localparam logic [1:0] CFG_TONE_CLOCK  = 2'd1;
    localparam logic [1:0] CFG_NOISE_CLOCK = 2'd2;

    // channel code of the noise generator in latch bytes and volume writes
    localparam logic [1:0] NOISE_CH = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_TONE,
        OP_NOISE,
        OP_VOLUME
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_WRITE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [1:0]         chan;
        logic [DIV_W-1:0]   divisor;
        logic [VOL_W-1:0]   volume;
    } op_t;

    typedef struct packed {
        logic               chip_enable;
        logic [CLK_W-1:0]   tone_clock;
        logic [CLK_W-1:0]   noise_clock;
    } cfg_t;

    // noise period 31/(mode+1)
    function automatic logic [NPER_W-1:0] noise_period(input logic [1:0] mode);
        logic [NPER_W-1:0] p;
        case (mode)
            2'd0:    p = 5'd31;
            2'd1:    p = 5'd15;
            2'd2:    p = 5'd10;
            default: p = 5'd7;
        endcase
        return p;
    endfunction

    function automatic logic [4:0] vol_weight(input logic [VOL_W-1:0] vol);
        logic [4:0] w;
        case (vol)
            4'd0:    w = 5'd24;
            4'd1:    w = 5'd20;
            4'd2:    w = 5'd16;
            4'd3:    w = 5'd15;
            4'd4:    w = 5'd10;
            4'd5:    w = 5'd8;
            4'd6:    w = 5'd6;
            4'd7:    w = 5'd4;
            4'd8:    w = 5'd3;
            4'd9:    w = 5'd2;
            4'd10:   w = 5'd2;
            4'd11:   w = 5'd1;
            4'd12:   w = 5'd1;
            4'd13:   w = 5'd1;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/psg_tone_noise_generator_core.sv
// Top level of the three-tone, one-noise sound generator: config registers and wiring.
`timescale 1ns / 1ps
// A tick on an empty queue passes from the queue slot through the back end's IDLE and EMIT states into m_tdata.
// A tick passes through the IDLE and EMIT states; a period write goes through IDLE, the 22 steps
// of the bit-serial divider and the increment write; a volume write is done when popped in IDLE.
// The four-entry operation queue takes transfers while the divider works or m_tready is low.
// Reset (aresetn low at a clock edge): chip enabled, default clocks, all phases, increments
// and the noise seed cleared, volumes silent, period bits all ones, queue empty.

module psg_tone_noise_generator_core #(
    parameter int SAMPLE_RATE  = 15600,
    parameter int PERIOD_SCALE = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic                     s_tuser,      // [0] command (0 port write, 1 tick)
    input  logic [7:0]               s_tdata,      // [7:0] port_byte
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,      // [7:0] mixed_sample, signed
    // configuration writes
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [psg_pkg::CLK_W-1:0] cfg_wr_data
);

    psg_pkg::cfg_t cfg_reg;

    logic          push;
    psg_pkg::op_t  push_op;
    logic          fifo_full;
    logic          pop;
    logic          head_valid;
    psg_pkg::op_t  head_op;

    // Hold configuration; writes must arrive only while the block is idle (the block does not enforce this).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chip_enable <= 1'b1;
            cfg_reg.tone_clock  <= psg_pkg::TONE_CLOCK_RESET;
            cfg_reg.noise_clock <= psg_pkg::NOISE_CLOCK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                psg_pkg::CFG_CHIP_ENABLE: cfg_reg.chip_enable <= cfg_wr_data[0];
                psg_pkg::CFG_TONE_CLOCK:  cfg_reg.tone_clock  <= cfg_wr_data;
                psg_pkg::CFG_NOISE_CLOCK: cfg_reg.noise_clock <= cfg_wr_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Classify each transfer and track the latched period bits.
    psg_front #(
        .PERIOD_SCALE (PERIOD_SCALE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .push      (push),
        .push_op   (push_op)
    );

    // Decouple the front end from the divider and the output stage.
    psg_op_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Execute operations in order: divide, advance channels, mix.
    psg_back #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .op_valid (head_valid),
        .op       (head_op),
        .op_pop   (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: hw/rtl/psg_front.sv
// Front end: accept port writes and ticks, track period bits, emit queued operations.
`timescale 1ns / 1ps

module psg_front #(
    parameter int PERIOD_SCALE = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,     // [0] command
    input  logic [7:0]          s_tdata,     // [7:0] port_byte
    input  logic                fifo_full,
    output logic                push,
    output psg_pkg::op_t        push_op
);

    logic [psg_pkg::PER_LO_W-1:0] lo_reg [3];
    logic [psg_pkg::PER_LO_W-1:0] lo_next [3];
    logic [psg_pkg::PER_HI_W-1:0] hi_reg [3];
    logic [psg_pkg::PER_HI_W-1:0] hi_next [3];
    logic [1:0]                   last_reg;
    logic [1:0]                   last_next;

    logic [2:0]                   reg_sel;
    logic [1:0]                   ch;
    logic [psg_pkg::PER_W-1:0]    period;
    logic [psg_pkg::PER_W-1:0]    period_eff;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;
    assign reg_sel  = s_tdata[6:4];
    assign ch       = reg_sel[2:1];

    always_comb begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        last_next = last_reg;
        period    = '0;
        push_op.kind    = psg_pkg::OP_TICK;
        push_op.chan    = ch;
        push_op.volume  = s_tdata[3:0];
        if (!s_tuser && s_tdata[7]) begin
            if (ch == psg_pkg::NOISE_CH) begin
                if (!reg_sel[0]) begin
                    push_op.kind = psg_pkg::OP_NOISE;
                    period = psg_pkg::PER_W'(psg_pkg::noise_period(s_tdata[1:0]));
                end else begin
                    push_op.kind = psg_pkg::OP_VOLUME;
                end
            end else if (!reg_sel[0]) begin
                push_op.kind = psg_pkg::OP_TONE;
                lo_next[ch]  = s_tdata[3:0];
                last_next    = ch;
                period       = {hi_reg[ch], s_tdata[3:0]};
            end else begin
                push_op.kind = psg_pkg::OP_VOLUME;
            end
        end else if (!s_tuser) begin
            // data byte: upper period bits of the last latched tone
            push_op.kind      = psg_pkg::OP_TONE;
            push_op.chan      = last_reg;
            hi_next[last_reg] = s_tdata[5:0];
            period            = {s_tdata[5:0], lo_reg[last_reg]};
        end
        period_eff = (period == '0) ? psg_pkg::PER_W'(1) : period;
        push_op.divisor = psg_pkg::DIV_W'(32'(period_eff) * PERIOD_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i] <= '1;
                hi_reg[i] <= '1;
            end
            last_reg <= '0;
        end else if (push) begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            last_reg <= last_next;
        end
    end

endmodule

FILE: hw/rtl/psg_op_fifo.sv
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps

module psg_op_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  psg_pkg::op_t   push_op,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output psg_pkg::op_t   head_op
);

    psg_pkg::op_t                  slot_reg [psg_pkg::FIFO_DEPTH];
    logic [psg_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [psg_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [psg_pkg::FIFO_AW:0]     count_reg;

    assign full       = (count_reg == (psg_pkg::FIFO_AW + 1)'(psg_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/psg_back.sv
// Back end: iterative increment divider, phase accumulators, noise LCG and mixer.
`timescale 1ns / 1ps

module psg_back #(
    parameter int SAMPLE_RATE = 15600
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  psg_pkg::cfg_t               cfg,
    input  logic                        op_valid,
    input  psg_pkg::op_t                op,
    output logic                        op_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [psg_pkg::SAMPLE_W-1:0] m_tdata
);

    localparam int PH_W = $clog2(SAMPLE_RATE);
    localparam logic [PH_W:0]            RATE_PH  = (PH_W + 1)'(SAMPLE_RATE);
    localparam logic [PH_W-1:0]          HALF_PH  = PH_W'(SAMPLE_RATE / 2);
    localparam logic [PH_W-1:0]          RATE_SAT = PH_W'(SAMPLE_RATE - 10);
    localparam logic [psg_pkg::CLK_W:0]  RATE_Q   = (psg_pkg::CLK_W + 1)'(SAMPLE_RATE);

    psg_pkg::back_state_t state_reg, state_next;

    logic [PH_W-1:0]                tone_phase_reg [3];
    logic [PH_W-1:0]                tone_phase_next [3];
    logic [PH_W-1:0]                tone_inc_reg [3];
    logic                           tone_neg_reg [3];
    logic [PH_W-1:0]                noise_phase_reg;
    logic [PH_W-1:0]                noise_phase_next;
    logic [PH_W-1:0]                noise_inc_reg;
    logic                           noise_neg_reg;
    logic                           noise_wrap;
    logic [psg_pkg::SEED_W-1:0]     seed_reg;
    logic [psg_pkg::SEED_W-1:0]     seed_step;
    logic [psg_pkg::VOL_W-1:0]      vol_reg [4];

    logic [psg_pkg::DIV_W-1:0]      rem_reg;
    logic [psg_pkg::CLK_W-1:0]      quo_reg;
    logic [psg_pkg::DIV_W-1:0]      dsr_reg;
    logic [psg_pkg::CNT_W-1:0]      cnt_reg;
    logic [1:0]                     job_chan_reg;
    logic                           job_noise_reg;
    logic [psg_pkg::DIV_W:0]        trial;
    logic [psg_pkg::DIV_W:0]        diff;
    logic                           trial_ge;
    logic [psg_pkg::CLK_W:0]        q_full;
    logic [PH_W-1:0]                inc_sat;

    logic                           out_valid_reg;
    logic [psg_pkg::SAMPLE_W-1:0]   out_data_reg;
    logic [psg_pkg::SAMPLE_W-1:0]   mix;
    logic                           emit;
    logic                           tick_go;
    logic                           div_go;
    logic                           vol_go;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psg_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_pop     = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            psg_pkg::BK_IDLE: begin
                if (op_valid) begin
                    op_pop = 1'b1;
                    if (op.kind == psg_pkg::OP_TICK) begin
                        state_next = psg_pkg::BK_EMIT;
                    end else if (op.kind inside {psg_pkg::OP_TONE, psg_pkg::OP_NOISE}) begin
                        state_next = psg_pkg::BK_DIV;
                    end
                end
            end
            psg_pkg::BK_DIV: begin
                if (cnt_reg == psg_pkg::CNT_W'(1)) begin
                    state_next = psg_pkg::BK_WRITE;
                end
            end
            psg_pkg::BK_WRITE: begin
                state_next = psg_pkg::BK_IDLE;
            end
            psg_pkg::BK_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    emit       = 1'b1;
                    state_next = psg_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = psg_pkg::BK_IDLE;
            end
        endcase
    end

    assign tick_go = op_pop && (op.kind == psg_pkg::OP_TICK) && cfg.chip_enable;
    assign div_go  = op_pop && (op.kind inside {psg_pkg::OP_TONE, psg_pkg::OP_NOISE});
    assign vol_go  = op_pop && (op.kind == psg_pkg::OP_VOLUME);

    // restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[psg_pkg::CLK_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign trial_ge = (trial >= {1'b0, dsr_reg});

    // noise quotient is doubled; saturate and pull exactly the rate down by ten
    assign q_full  = job_noise_reg ? {quo_reg, 1'b0} : {1'b0, quo_reg};
    assign inc_sat = (q_full >= RATE_Q) ? RATE_SAT : q_full[PH_W-1:0];

    always_comb begin
        logic [PH_W:0] sum;
        logic [PH_W:0] nsum;
        for (int i = 0; i < 3; i++) begin
            sum = {1'b0, tone_phase_reg[i]} + {1'b0, tone_inc_reg[i]};
            tone_phase_next[i] = (sum >= RATE_PH) ? PH_W'(sum - RATE_PH) : sum[PH_W-1:0];
        end
        nsum = {1'b0, noise_phase_reg} + {1'b0, noise_inc_reg};
        noise_wrap = (nsum >= RATE_PH);
        noise_phase_next = noise_wrap ? PH_W'(nsum - RATE_PH) : nsum[PH_W-1:0];
    end

    assign seed_step = psg_pkg::SEED_W'((seed_reg + 1'b1) * psg_pkg::LCG_MULT) - 1'b1;

    always_comb begin
        logic [psg_pkg::SAMPLE_W-1:0] w;
        mix = '0;
        for (int i = 0; i < 3; i++) begin
            w   = psg_pkg::SAMPLE_W'(psg_pkg::vol_weight(vol_reg[i]));
            mix = tone_neg_reg[i] ? mix - w : mix + w;
        end
        w   = psg_pkg::SAMPLE_W'(psg_pkg::vol_weight(vol_reg[psg_pkg::NOISE_CH]));
        mix = noise_neg_reg ? mix - w : mix + w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                tone_phase_reg[i] <= '0;
                tone_inc_reg[i]   <= '0;
                tone_neg_reg[i]   <= 1'b0;
            end
            for (int i = 0; i < 4; i++) begin
                vol_reg[i] <= '1;
            end
            noise_phase_reg <= '0;
            noise_inc_reg   <= '0;
            noise_neg_reg   <= 1'b0;
            seed_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (tick_go) begin
                for (int i = 0; i < 3; i++) begin
                    tone_neg_reg[i]   <= (tone_phase_reg[i] >= HALF_PH);
                    tone_phase_reg[i] <= tone_phase_next[i];
                end
                noise_phase_reg <= noise_phase_next;
                if (noise_wrap) begin
                    seed_reg      <= seed_step;
                    noise_neg_reg <= seed_step[psg_pkg::SEED_W-1];
                end
            end
            if (vol_go) begin
                vol_reg[op.chan] <= op.volume;
            end
            if (state_reg == psg_pkg::BK_WRITE) begin
                if (job_noise_reg) begin
                    noise_inc_reg <= inc_sat;
                end else begin
                    tone_inc_reg[job_chan_reg] <= inc_sat;
                end
            end
            if (div_go) begin
                cnt_reg <= psg_pkg::CNT_W'(psg_pkg::CLK_W);
            end else if (state_reg == psg_pkg::BK_DIV) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_go) begin
            rem_reg       <= '0;
            quo_reg       <= (op.kind == psg_pkg::OP_NOISE) ? cfg.noise_clock : cfg.tone_clock;
            dsr_reg       <= op.divisor;
            job_chan_reg  <= op.chan;
            job_noise_reg <= (op.kind == psg_pkg::OP_NOISE);
        end else if (state_reg == psg_pkg::BK_DIV) begin
            rem_reg <= trial_ge ? diff[psg_pkg::DIV_W-1:0] : trial[psg_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[psg_pkg::CLK_W-2:0], trial_ge};
        end
        if (emit) begin
            out_data_reg <= cfg.chip_enable ? mix : '0;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, tone_phase_reg[0]} < RATE_PH) && ({1'b0, tone_phase_reg[1]} < RATE_PH) &&
        ({1'b0, tone_phase_reg[2]} < RATE_PH) && ({1'b0, noise_phase_reg} < RATE_PH))
        else $error("phase accumulator outside the sample period");

    a_inc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, tone_inc_reg[0]} < RATE_PH) && ({1'b0, tone_inc_reg[1]} < RATE_PH) &&
        ({1'b0, tone_inc_reg[2]} < RATE_PH) && ({1'b0, noise_inc_reg} < RATE_PH))
        else $error("increment not saturated below the sample rate");

    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($signed(out_data_reg) >= -96) && ($signed(out_data_reg) <= 96))
        else $error("mixed sample outside the four-channel range");

    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == psg_pkg::BK_EMIT)
        else $error("result raised without a tick being emitted");

endmodule
